// ----- rtl/core/fta_pkg.sv -----
// ----------------------------------------------------------------------------
// fta_pkg
// Shared widths, request codes and controller states of the frame time
// averager.
// ----------------------------------------------------------------------------
package fta_pkg;

  localparam int unsigned TS_W   = 48;  // timestamp and total time width
  localparam int unsigned AVG_W  = 32;  // average interval width
  localparam int unsigned RATE_W = 16;  // frame rate width
  localparam int unsigned TPS_W  = 32;  // ticks per second register width
  localparam int unsigned ACC_W  = 33;  // per-second interval accumulator
  localparam int unsigned REQ_W  = 2;

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(10000000);

  typedef enum logic [REQ_W-1:0] {
    REQ_FRAME = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_START = 2'd2,
    REQ_RESET = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/core/fta_in_if.sv -----
// ----------------------------------------------------------------------------
// fta_in_if
// Request channel: request type and counter timestamp with valid/ready.
// ----------------------------------------------------------------------------
interface fta_in_if;
  import fta_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [TS_W-1:0]  timestamp;

  modport source (output valid, output req_type, output timestamp, input ready);
  modport sink   (input valid, input req_type, input timestamp, output ready);
endinterface

// ----- rtl/core/fta_out_if.sv -----
// ----------------------------------------------------------------------------
// fta_out_if
// Result channel: average, frame rate, unpaused time and stopped flag.
// ----------------------------------------------------------------------------
interface fta_out_if;
  import fta_pkg::*;

  logic              valid;
  logic              ready;
  logic [AVG_W-1:0]  avg_frame_ticks;
  logic [RATE_W-1:0] frame_rate;
  logic [TS_W-1:0]   total_ticks;
  logic              is_stopped;

  modport source (output valid, output avg_frame_ticks, output frame_rate,
                  output total_ticks, output is_stopped, input ready);
  modport sink   (input valid, input avg_frame_ticks, input frame_rate,
                  input total_ticks, input is_stopped, output ready);
endinterface

// ----- rtl/core/frame_time_averager_core.sv -----
// ----------------------------------------------------------------------------
// frame_time_averager_core
// Frame interval averaging timer with pause accounting.
// Flow: a running frame passes through update, divider start, the bit-serial
//   window-sum divide and done before its result is registered at the output.
//   Stop, start, reset and stopped frames go straight to done.
// One request at a time: the next request is accepted only once the result
//   sits in the output register; done waits while the output is held.
// Reset: asynchronous, active low; timer state resets, the interval RAM, stamp
//   and output data are not cleared (RAM entries are only used once written).
// ----------------------------------------------------------------------------
module frame_time_averager_core #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  fta_in_if.sink                    in_i,
  fta_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [fta_pkg::TPS_W-1:0] cfg_wdata_i
);
  import fta_pkg::*;

  localparam int unsigned HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = AVG_W + CNT_W;

  state_e state_q, state_d;

  logic [TPS_W-1:0]  tps_q;
  logic              stopped_q, stopped_d;
  logic [TS_W-1:0]   base_q, base_d;
  logic [TS_W-1:0]   last_q, last_d;
  logic [TS_W-1:0]   cur_q, cur_d;
  logic [TS_W-1:0]   paused_q, paused_d;
  logic [TS_W-1:0]   stop_q, stop_d;
  logic [AVG_W-1:0]  avg_q, avg_d;
  logic [HEAD_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [RATE_W-1:0] frames_q, frames_d;
  logic [ACC_W-1:0]  accum_q, accum_d;
  logic [RATE_W-1:0] rate_q, rate_d;

  logic [TS_W-1:0]   stamp_q;

  logic              out_valid_q, out_valid_d;
  logic [AVG_W-1:0]  out_avg_q;
  logic [RATE_W-1:0] out_rate_q;
  logic [TS_W-1:0]   out_total_q;
  logic              out_stop_q;

  logic              in_fire;
  logic              out_load;
  logic              frame_run;

  logic [TS_W-1:0]   interval;
  logic [TS_W-1:0]   avg_ext;
  logic [TS_W-1:0]   diff;
  logic              take;
  logic [AVG_W-1:0]  sample;
  logic              full;
  logic [AVG_W-1:0]  old_sample;
  logic [ACC_W:0]    accum_sum;
  logic [ACC_W-1:0]  accum_sat;
  logic [RATE_W-1:0] frames_inc;

  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  logic [TS_W-1:0]   ref_stamp;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign frame_run  = (req_e'(in_i.req_type) == REQ_FRAME) && !stopped_q;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  assign div_start  = (state_q == ST_START);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = frame_run ? ST_UPDATE : ST_DONE;
        end
      end
      ST_UPDATE: state_d = ST_START;
      ST_START:  state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // frame update arithmetic
  always_comb begin
    interval   = stamp_q - last_q;
    avg_ext    = TS_W'(avg_q);
    diff       = (interval >= avg_ext) ? (interval - avg_ext) : (avg_ext - interval);
    take       = diff < TS_W'(tps_q);
    sample     = (|interval[TS_W-1:AVG_W]) ? '1 : interval[AVG_W-1:0];
    full       = count_q == CNT_W'(WINDOW_DEPTH);
    accum_sum  = (ACC_W+1)'(accum_q) + (ACC_W+1)'(interval[ACC_W-1:0]);
    // saturate on a carry out or on any interval bit above the accumulator
    accum_sat  = (accum_sum[ACC_W] || (|interval[TS_W-1:ACC_W])) ? '1
                                                                  : accum_sum[ACC_W-1:0];
    frames_inc = (&frames_q) ? frames_q : frames_q + RATE_W'(1);
  end

  // state updates and outputs
  always_comb begin
    stopped_d   = stopped_q;
    base_d      = base_q;
    last_d      = last_q;
    cur_d       = cur_q;
    paused_d    = paused_q;
    stop_d      = stop_q;
    avg_d       = avg_q;
    head_d      = head_q;
    count_d     = count_q;
    sum_d       = sum_q;
    frames_d    = frames_q;
    accum_d     = accum_q;
    rate_d      = rate_q;
    out_valid_d = out_valid_q;

    if (in_fire) begin
      case (req_e'(in_i.req_type))
        REQ_FRAME: begin
          if (stopped_q) begin
            avg_d = '0;
          end
        end
        REQ_STOP: begin
          if (!stopped_q) begin
            stop_d    = in_i.timestamp;
            stopped_d = 1'b1;
          end
        end
        REQ_START: begin
          if (stopped_q) begin
            paused_d  = paused_q + in_i.timestamp - stop_q;
            last_d    = in_i.timestamp;
            stop_d    = '0;
            stopped_d = 1'b0;
          end
        end
        REQ_RESET: begin
          base_d    = in_i.timestamp;
          last_d    = in_i.timestamp;
          stop_d    = '0;
          stopped_d = 1'b0;
        end
        default: ;
      endcase
    end

    if (state_q == ST_UPDATE) begin
      cur_d  = stamp_q;
      last_d = stamp_q;
      if (take) begin
        // drop the oldest sample once the window is full
        sum_d  = sum_q - (full ? SUM_W'(old_sample) : '0) + SUM_W'(sample);
        if (!full) begin
          count_d = count_q + CNT_W'(1);
        end
        head_d = (head_q == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + HEAD_W'(1);
      end
      if (accum_sat > ACC_W'(tps_q)) begin
        rate_d   = frames_inc;
        frames_d = '0;
        accum_d  = '0;
      end else begin
        frames_d = frames_inc;
        accum_d  = accum_sat;
      end
    end

    if ((state_q == ST_DIVIDE) && div_done) begin
      if (count_q == '0) begin
        avg_d = '0;
      end else begin
        avg_d = (|div_quo[SUM_W-1:AVG_W]) ? '1 : div_quo[AVG_W-1:0];
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign ref_stamp = stopped_q ? stop_q : cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tps_q       <= TPS_RESET;
      stopped_q   <= 1'b0;
      base_q      <= '0;
      last_q      <= '0;
      cur_q       <= '0;
      paused_q    <= '0;
      stop_q      <= '0;
      avg_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      frames_q    <= '0;
      accum_q     <= '0;
      rate_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      stopped_q   <= stopped_d;
      base_q      <= base_d;
      last_q      <= last_d;
      cur_q       <= cur_d;
      paused_q    <= paused_d;
      stop_q      <= stop_d;
      avg_q       <= avg_d;
      head_q      <= head_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      frames_q    <= frames_d;
      accum_q     <= accum_d;
      rate_q      <= rate_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stamp_q <= in_i.timestamp;
    end
    if (out_load) begin
      out_avg_q   <= avg_q;
      out_rate_q  <= rate_q;
      out_total_q <= ref_stamp - paused_q - base_q;
      out_stop_q  <= stopped_q;
    end
  end

  fta_ram #(
    .WIDTH (AVG_W),
    .DEPTH (WINDOW_DEPTH),
    .ADDR_W(HEAD_W)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   ((state_q == ST_UPDATE) && take),
    .waddr_i(head_q),
    .wdata_i(sample),
    .re_i   (in_fire),
    .raddr_i(head_q),
    .rdata_o(old_sample)
  );

  fta_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (sum_q),
    .den_i  (count_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.avg_frame_ticks = out_avg_q;
  assign out_o.frame_rate      = out_rate_q;
  assign out_o.total_ticks     = out_total_q;
  assign out_o.is_stopped      = out_stop_q;

endmodule

// ----- rtl/core/fta_ram.sv -----
// ----------------------------------------------------------------------------
// fta_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fta_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/core/fta_div.sv -----
// ----------------------------------------------------------------------------
// fta_div
// Restoring radix-2 divider: one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module fta_div #(
  parameter int unsigned NUM_W = 39,
  parameter int unsigned DEN_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W:0]   rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_shift;
  logic             bit_set;
  logic [DEN_W:0]   rem_next;

  always_comb begin
    rem_shift = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    bit_set   = rem_shift >= {1'b0, den_q};
    rem_next  = bit_set ? (rem_shift - {1'b0, den_q}) : rem_shift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[NUM_W-2:0], bit_set};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
